[hw/rtl/square_matrix_multiply_unit_assert.svh]
// Assertion macros for the matrix multiply RTL.
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/smm_pkg.sv]
// Shared widths, operation codes and control types of the matrix multiply unit.
package smm_pkg;

  localparam int MATRIX_SIZE_DEF = 8;
  localparam int OP_W            = 2;
  localparam int IDX_W           = 6;
  localparam int ELEM_W          = 16;
  localparam int MUL_W           = 2 * ELEM_W;
  localparam int PROD_W          = 38;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/smm_if.sv]
// Valid/ready channel interfaces for input and result transactions.
interface smm_in_if;
  logic                              valid;
  logic                              ready;
  logic        [smm_pkg::OP_W-1:0]   operation;
  logic        [smm_pkg::IDX_W-1:0]  row_index;
  logic        [smm_pkg::IDX_W-1:0]  col_index;
  logic signed [smm_pkg::ELEM_W-1:0] element_value;

  modport source (output valid, operation, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, operation, row_index, col_index, element_value,
                  output ready);
endinterface

interface smm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [smm_pkg::PROD_W-1:0] product_value;
  logic                              index_error;

  modport source (output valid, product_value, index_error, input ready);
  modport sink   (input valid, product_value, index_error, output ready);
endinterface

[hw/rtl/smm_datapath.sv]
// Element stores, multiply-accumulate pipeline and result register.
module smm_datapath #(
  parameter int MATRIX_SIZE = smm_pkg::MATRIX_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic        [smm_pkg::IDX_W-1:0]  row_index,
  input  logic        [smm_pkg::IDX_W-1:0]  col_index,
  input  logic signed [smm_pkg::ELEM_W-1:0] element_value,
  input  smm_pkg::cmd_t                     cmd_i,
  output smm_pkg::sts_t                     sts_o,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [smm_pkg::PROD_W-1:0] out_product_value,
  output logic                              out_index_error
);

  localparam int CELL_COUNT = MATRIX_SIZE * MATRIX_SIZE;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  logic signed [smm_pkg::ELEM_W-1:0] mem_a [CELL_COUNT];
  logic signed [smm_pkg::ELEM_W-1:0] mem_b [CELL_COUNT];

  logic        [ADDR_W-1:0]          cell_addr;
  logic        [ADDR_W-1:0]          a_addr_r, a_addr_nxt;
  logic        [ADDR_W-1:0]          b_addr_r, b_addr_nxt;
  logic signed [smm_pkg::ELEM_W-1:0] a_q_r, b_q_r;
  logic signed [smm_pkg::MUL_W-1:0]  mul_r;
  logic signed [smm_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic                              err_r, err_nxt;
  logic                              rd_v_r, mul_v_r;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [smm_pkg::PROD_W-1:0] out_prod_r;
  logic                              out_err_r;
  logic                              in_range;

  assign in_range  = (32'(row_index) < MATRIX_SIZE) && (32'(col_index) < MATRIX_SIZE);
  assign cell_addr = ADDR_W'(row_index) * ADDR_W'(MATRIX_SIZE) + ADDR_W'(col_index);

  always_ff @(posedge clk) begin
    if (cmd_i.load_a) begin
      mem_a[cell_addr] <= element_value;
    end
    if (cmd_i.issue) begin
      a_q_r <= mem_a[a_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_b) begin
      mem_b[cell_addr] <= element_value;
    end
    if (cmd_i.issue) begin
      b_q_r <= mem_b[b_addr_r];
    end
  end

  always_comb begin
    a_addr_nxt = a_addr_r;
    b_addr_nxt = b_addr_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    if (cmd_i.start) begin
      a_addr_nxt = ADDR_W'(row_index) * ADDR_W'(MATRIX_SIZE);
      b_addr_nxt = ADDR_W'(col_index);
      acc_nxt    = '0;
      err_nxt    = !in_range;
    end else begin
      if (cmd_i.issue) begin
        a_addr_nxt = a_addr_r + ADDR_W'(1);
        b_addr_nxt = b_addr_r + ADDR_W'(MATRIX_SIZE);
      end
      if (mul_v_r) begin
        acc_nxt = acc_r + smm_pkg::PROD_W'(mul_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    acc_r    <= acc_nxt;
    err_r    <= err_nxt;
    mul_r    <= a_q_r * b_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd_i.issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      out_prod_r <= err_r ? '0 : acc_r;
      out_err_r  <= err_r;
    end
  end

  assign sts_o.in_range   = in_range;
  assign sts_o.pipe_empty = !rd_v_r && !mul_v_r;
  assign sts_o.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_product_value = out_prod_r;
  assign out_index_error   = out_err_r;

endmodule

[hw/rtl/smm_ctrl.sv]
// Sequencer for loads and product queries of the matrix multiply unit.
`include "square_matrix_multiply_unit_assert.svh"

module smm_ctrl #(
  parameter int MATRIX_SIZE = smm_pkg::MATRIX_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [smm_pkg::OP_W-1:0] in_operation,
  output logic                     in_ready,
  input  smm_pkg::sts_t            sts_i,
  output smm_pkg::cmd_t            cmd_o
);

  localparam int K_W = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam logic [K_W-1:0] LAST = K_W'(MATRIX_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [K_W-1:0] cnt_r, cnt_nxt;
  logic           accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            smm_pkg::OP_LOAD_A: cmd_o.load_a = sts_i.in_range;
            smm_pkg::OP_LOAD_B: cmd_o.load_b = sts_i.in_range;
            smm_pkg::OP_QUERY: begin
              cmd_o.start = 1'b1;
              cnt_nxt     = '0;
              state_nxt   = sts_i.in_range ? ST_RUN : ST_DRAIN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        cnt_nxt     = cnt_r + K_W'(1);
        if (cnt_r == LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty && sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `SMM_ASSERT_SAME(a_finish_free, cmd_o.finish, sts_i.out_free && sts_i.pipe_empty)
  `SMM_ASSERT_SAME(a_load_idle, cmd_o.load_a || cmd_o.load_b, state_r == ST_IDLE && accept)
  `SMM_ASSERT_NEXT(a_last_issue, state_r == ST_RUN && cnt_r == LAST, state_r == ST_DRAIN)
  `SMM_ASSERT_NEXT(a_finish_idle, cmd_o.finish, state_r == ST_IDLE)

endmodule

[hw/rtl/square_matrix_multiply_unit.sv]
// A load writes its store when it is accepted. A product query steps the single
// multiply-accumulate along the row and column, reading one A and one B element per cycle
// from the two stores, then waits for a free result register; an out-of-range query skips
// the multiply-accumulate. No new item is accepted until a query's result is registered.
// Reset: synchronous active-low rst_n clears control state; the element stores are not
// cleared and hold undefined data until loaded.
module square_matrix_multiply_unit #(
  parameter int MATRIX_SIZE = smm_pkg::MATRIX_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  smm_in_if.sink    in_bus,
  smm_out_if.source out_bus
);

  smm_pkg::cmd_t cmd;
  smm_pkg::sts_t sts;

  smm_ctrl #(
    .MATRIX_SIZE(MATRIX_SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_operation (in_bus.operation),
    .in_ready     (in_bus.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  smm_datapath #(
    .MATRIX_SIZE(MATRIX_SIZE)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .row_index         (in_bus.row_index),
    .col_index         (in_bus.col_index),
    .element_value     (in_bus.element_value),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_product_value (out_bus.product_value),
    .out_index_error   (out_bus.index_error)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for the square matrix multiply unit: element loads and product queries.
`timescale 1ns / 1ps

module testbench;

  localparam int N           = smm_pkg::MATRIX_SIZE_DEF;
  localparam int CELLS       = N * N;
  localparam int ITEM_TARGET = 1500;
  localparam int TAIL_ITEMS  = 50;
  localparam logic [smm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int {STYLE_FULL, STYLE_EXTREME, STYLE_SMALL} value_style_t;
  typedef enum int {SEQ_ROW_COL, SEQ_SCATTER, SEQ_NOISE} sequence_kind_t;

  typedef struct {
    logic signed [smm_pkg::PROD_W-1:0] product_value;
    logic                              index_error;
  } product_result_t;

  logic clk;
  logic rst_n;

  smm_in_if  in_bus();
  smm_out_if out_bus();

  logic signed [smm_pkg::ELEM_W-1:0] a_cells [CELLS];
  logic signed [smm_pkg::ELEM_W-1:0] b_cells [CELLS];
  bit                                a_loaded [CELLS];
  bit                                b_loaded [CELLS];
  product_result_t                   expected_products [$];

  bit send_gaps_on;
  bit sink_stalls_on;
  int mismatch_count;
  int loads_done;
  int queries_done;
  int range_errors;
  int ignored_items;
  int results_checked;

  square_matrix_multiply_unit #(.MATRIX_SIZE(N)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic signed [smm_pkg::PROD_W-1:0] dot_row_col(int r, int c);
    longint acc;
    int     k;
    acc = 0;
    for (k = 0; k < N; k++) begin
      acc += longint'(a_cells[r*N+k]) * longint'(b_cells[k*N+c]);
    end
    return acc[smm_pkg::PROD_W-1:0];
  endfunction

  function automatic bit row_col_loaded(int r, int c);
    int k;
    for (k = 0; k < N; k++) begin
      if (!a_loaded[r*N+k] || !b_loaded[k*N+c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit pick_readable(output int r, output int c);
    int rows [$];
    int cols [$];
    int rr;
    int cc;
    int pick;
    for (rr = 0; rr < N; rr++) begin
      for (cc = 0; cc < N; cc++) begin
        if (row_col_loaded(rr, cc)) begin
          rows.push_back(rr);
          cols.push_back(cc);
        end
      end
    end
    if (rows.size() == 0) return 1'b0;
    pick = $urandom_range(0, rows.size() - 1);
    r = rows[pick];
    c = cols[pick];
    return 1'b1;
  endfunction

  function automatic logic signed [smm_pkg::ELEM_W-1:0] pick_element(value_style_t style);
    logic signed [smm_pkg::ELEM_W-1:0] v;
    case (style)
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          3: v = 16'h0001;
          default: v = 16'h0000;
        endcase
      end
      STYLE_SMALL: begin
        v = smm_pkg::ELEM_W'($urandom_range(0, 8));
        v = v - 16'sd4;
      end
      default: v = smm_pkg::ELEM_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(logic [smm_pkg::OP_W-1:0] op, int row, int col,
                           logic signed [smm_pkg::ELEM_W-1:0] value);
    bit              in_range;
    product_result_t result;
    in_range = row < N && col < N;
    if (send_gaps_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.operation     <= op;
    in_bus.row_index     <= smm_pkg::IDX_W'(row);
    in_bus.col_index     <= smm_pkg::IDX_W'(col);
    in_bus.element_value <= value;
    do @(posedge clk); while (!in_bus.ready);
    case (op)
      smm_pkg::OP_LOAD_A: begin
        if (in_range) begin
          a_cells[row*N+col]  = value;
          a_loaded[row*N+col] = 1'b1;
          loads_done++;
        end else begin
          ignored_items++;
        end
      end
      smm_pkg::OP_LOAD_B: begin
        if (in_range) begin
          b_cells[row*N+col]  = value;
          b_loaded[row*N+col] = 1'b1;
          loads_done++;
        end else begin
          ignored_items++;
        end
      end
      smm_pkg::OP_QUERY: begin
        result.index_error   = !in_range;
        result.product_value = in_range ? dot_row_col(row, col) : '0;
        expected_products.push_back(result);
        queries_done++;
        if (!in_range) range_errors++;
      end
      default: ignored_items++;
    endcase
    @(negedge clk);
  endtask

  // Drive the largest magnitudes through row 0 of A and column 0 of B.
  task automatic test_extreme_products();
    int k;
    for (k = 0; k < N; k++) send_item(smm_pkg::OP_LOAD_A, 0, k, 16'h8000);
    for (k = 0; k < N; k++) send_item(smm_pkg::OP_LOAD_B, k, 0, 16'h8000);
    send_item(smm_pkg::OP_QUERY, 0, 0, 16'h0000);
    send_item(smm_pkg::OP_LOAD_B, 0, 0, 16'h7fff);
    send_item(smm_pkg::OP_QUERY, 0, 0, 16'hffff);
  endtask

  // Out-of-range loads alias onto cells feeding product (0,0) if index math is wrong.
  task automatic test_range_and_ignored();
    send_item(smm_pkg::OP_LOAD_A, N, 0, 16'h5555);
    send_item(smm_pkg::OP_LOAD_B, 0, N, 16'haaaa);
    send_item(OP_UNUSED, 0, 0, 16'h1234);
    send_item(smm_pkg::OP_QUERY, N, 0, 16'h7fff);
    send_item(smm_pkg::OP_QUERY, 0, 63, 16'h8000);
    send_item(smm_pkg::OP_QUERY, 0, 0, 16'h0000);
  endtask

  task automatic test_random_products();
    sequence_kind_t kind;
    value_style_t   style;
    int             r;
    int             c;
    int             k;
    int             pick;
    int             rr;
    int             cc;
    while (loads_done + queries_done + ignored_items < ITEM_TARGET) begin
      send_gaps_on   = $urandom_range(0, 3) != 0;
      sink_stalls_on = $urandom_range(0, 3) != 0;
      style = value_style_t'($urandom_range(0, 2));
      pick  = $urandom_range(0, 9);
      kind  = pick < 5 ? SEQ_ROW_COL : (pick < 8 ? SEQ_SCATTER : SEQ_NOISE);
      r = $urandom_range(0, N - 1);
      c = $urandom_range(0, N - 1);
      case (kind)
        SEQ_ROW_COL: begin
          for (k = 0; k < N; k++) begin
            if ($urandom_range(0, 1)) begin
              if (!a_loaded[r*N+k] || $urandom_range(0, 1))
                send_item(smm_pkg::OP_LOAD_A, r, k, pick_element(style));
              if (!b_loaded[k*N+c] || $urandom_range(0, 1))
                send_item(smm_pkg::OP_LOAD_B, k, c, pick_element(style));
            end else begin
              if (!b_loaded[k*N+c] || $urandom_range(0, 1))
                send_item(smm_pkg::OP_LOAD_B, k, c, pick_element(style));
              if (!a_loaded[r*N+k] || $urandom_range(0, 1))
                send_item(smm_pkg::OP_LOAD_A, r, k, pick_element(style));
            end
          end
          send_item(smm_pkg::OP_QUERY, r, c, pick_element(STYLE_FULL));
          repeat ($urandom_range(0, 3)) begin
            if (pick_readable(rr, cc))
              send_item(smm_pkg::OP_QUERY, rr, cc, pick_element(STYLE_FULL));
          end
        end
        SEQ_SCATTER: begin
          repeat ($urandom_range(1, 6)) begin
            send_item($urandom_range(0, 1) ? smm_pkg::OP_LOAD_A : smm_pkg::OP_LOAD_B,
                      $urandom_range(0, N - 1), $urandom_range(0, N - 1), pick_element(style));
          end
          repeat ($urandom_range(1, 3)) begin
            if (pick_readable(rr, cc))
              send_item(smm_pkg::OP_QUERY, rr, cc, pick_element(STYLE_FULL));
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            rr = $urandom_range(0, 63);
            cc = $urandom_range(0, 63);
            if (rr < N && cc < N) begin
              if ($urandom_range(0, 1)) rr = $urandom_range(N, 63);
              else cc = $urandom_range(N, 63);
            end
            case ($urandom_range(0, 3))
              0: send_item(smm_pkg::OP_LOAD_A, rr, cc, pick_element(STYLE_FULL));
              1: send_item(smm_pkg::OP_LOAD_B, rr, cc, pick_element(STYLE_FULL));
              2: send_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                           pick_element(STYLE_FULL));
              default: send_item(smm_pkg::OP_QUERY, rr, cc, pick_element(STYLE_FULL));
            endcase
          end
        end
      endcase
    end
  endtask

  task automatic test_back_to_back();
    int r;
    int c;
    send_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (TAIL_ITEMS) begin
      if ($urandom_range(0, 2) == 0 && pick_readable(r, c)) begin
        send_item(smm_pkg::OP_QUERY, r, c, pick_element(STYLE_FULL));
      end else begin
        send_item($urandom_range(0, 1) ? smm_pkg::OP_LOAD_A : smm_pkg::OP_LOAD_B,
                  $urandom_range(0, N - 1), $urandom_range(0, N - 1), pick_element(STYLE_FULL));
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    product_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_products.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected transaction: expected none actual product %0d index_error %0b",
                 $time, out_bus.product_value, out_bus.index_error);
      end else begin
        want = expected_products.pop_front();
        results_checked++;
        if (out_bus.product_value !== want.product_value) begin
          mismatch_count++;
          $display("%0t product_value mismatch: expected %0d actual %0d",
                   $time, want.product_value, out_bus.product_value);
        end
        if (out_bus.index_error !== want.index_error) begin
          mismatch_count++;
          $display("%0t index_error mismatch: expected %0b actual %0b",
                   $time, want.index_error, out_bus.index_error);
        end
      end
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.operation     = '0;
    in_bus.row_index     = '0;
    in_bus.col_index     = '0;
    in_bus.element_value = '0;
    send_gaps_on         = 1'b1;
    sink_stalls_on       = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extreme_products();
    test_range_and_ignored();
    test_random_products();
    test_back_to_back();

    in_bus.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (2 * N + 8) @(posedge clk);

    $display("covered %0d element loads and %0d product queries (%0d out of range)",
             loads_done, queries_done, range_errors);
    $display("%0d ignored transactions, %0d results checked, %0d mismatches",
             ignored_items, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
